### hdl/lngt_pkg.sv
// shared constants and types for the lane nearest-vehicle gap tracker
`timescale 1ns / 1ps
`default_nettype none
package lngt_pkg;

	// field widths
	localparam int VelW     = 16;
	localparam int SpeedW   = 16;
	localparam int SW       = 20;
	localparam int PosW     = 21;
	localparam int DW       = 12;
	localparam int LaneW    = 2;
	localparam int HorizonW = 6;
	localparam int GapW     = 16;
	localparam int ResW     = 17;
	localparam int RadW     = 2 * SpeedW;

	// horizon saturation; HsatW covers the full range of the limit
	localparam int MAX_HORIZON = 63;
	localparam int HsatW       = 8;

	// lane bands are 256 units wide, so the band index is d from bit 8 up
	localparam int LaneShift = 8;
	localparam int BandW     = DW - LaneShift;
	localparam logic [LaneW-1:0] RightmostLane = 2'd2;

	// shared multiplier
	localparam int MulW  = 22;
	localparam int ProdW = 2 * MulW;

	// floor(x/200) = floor((x >> 3) / 25), the /25 by reciprocal, exact below 2^21
	localparam int DivPreShift = 3;
	localparam int RecipShift  = 26;
	localparam logic [MulW-1:0] RecipMul = 22'd2684355;
	localparam int QuotW = 17;

	// trackers
	localparam int NTrack         = 5;
	localparam int TrkAhead       = 0;
	localparam int TrkLeftAhead   = 1;
	localparam int TrkLeftBehind  = 2;
	localparam int TrkRightAhead  = 3;
	localparam int TrkRightBehind = 4;
	localparam logic [GapW-1:0] GAP_LIMIT = 16'd64000;

	typedef logic signed [ResW-1:0] res_t;

	typedef struct packed {
		logic clr;
		logic upd;
	} trk_ctl_t;

endpackage
`default_nettype wire

### hdl/lngt_if.sv
// handshake channels for vehicle items and result items
`timescale 1ns / 1ps
`default_nettype none
interface lngt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        first;
	logic                        last;
	logic [1:0]                  ego_lane;
	logic [5:0]                  horizon_steps;
	logic [20:0]                 ego_s;
	logic signed [15:0]          obj_vx;
	logic signed [15:0]          obj_vy;
	logic [19:0]                 obj_s;
	logic [11:0]                 obj_d;

	modport source (
		output valid, first, last, ego_lane, horizon_steps, ego_s,
		output obj_vx, obj_vy, obj_s, obj_d,
		input  ready
	);
	modport sink (
		input  valid, first, last, ego_lane, horizon_steps, ego_s,
		input  obj_vx, obj_vy, obj_s, obj_d,
		output ready
	);
endinterface

interface lngt_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] ahead_gap;
	logic signed [16:0] ahead_speed;
	logic signed [16:0] left_ahead_gap;
	logic signed [16:0] left_ahead_speed;
	logic signed [16:0] left_behind_gap;
	logic signed [16:0] left_behind_speed;
	logic signed [16:0] right_ahead_gap;
	logic signed [16:0] right_ahead_speed;
	logic signed [16:0] right_behind_gap;
	logic signed [16:0] right_behind_speed;

	modport source (
		output valid, ahead_gap, ahead_speed, left_ahead_gap, left_ahead_speed,
		output left_behind_gap, left_behind_speed, right_ahead_gap, right_ahead_speed,
		output right_behind_gap, right_behind_speed,
		input  ready
	);
	modport sink (
		input  valid, ahead_gap, ahead_speed, left_ahead_gap, left_ahead_speed,
		input  left_behind_gap, left_behind_speed, right_ahead_gap, right_ahead_speed,
		input  right_behind_gap, right_behind_speed,
		output ready
	);
endinterface
`default_nettype wire

### hdl/lane_nearest_vehicle_gap_tracker.sv
// top level: item sequencer around the shared multiplier, square root and trackers
//
// Takes one tracked vehicle per item and keeps the nearest vehicle ahead in the
// ego lane and ahead and behind in the left and right neighbor lanes, with a
// gap below 64000. Speed is floor(sqrt(vx^2 + vy^2)) and the predicted position
// adds floor(speed * horizon / 200). An item with first set clears the trackers
// before use; an item with last set produces one result item with the five
// gaps and speeds, -1 where no vehicle was found. Each vehicle goes through the
// squares, a wait on the bit-serial square-root unit, the speed-times-horizon
// product, the division by 200 (a reciprocal multiply) and the tracker update
// before the next item can be taken; the squares, the product and the division
// go through one shared multiplier. An item with last set then goes through an
// emit step that copies the trackers into the output register, and stays there
// while the previous result item has not been taken; the next item can be
// accepted while the new result waits.
`timescale 1ns / 1ps
`default_nettype none
module lane_nearest_vehicle_gap_tracker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lngt_in_if.sink    veh,
	lngt_out_if.source res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_SUM,
		S_ROOT,
		S_MULH,
		S_MULR,
		S_UPD,
		S_EMIT
	} state_t;

	state_t state_q;

	logic                            last_q;
	logic [lngt_pkg::LaneW-1:0]      lane_q;
	logic [lngt_pkg::HsatW-1:0]      h_q;
	logic [lngt_pkg::PosW-1:0]       ego_q;
	logic [lngt_pkg::VelW-1:0]       vxa_q;
	logic [lngt_pkg::VelW-1:0]       vya_q;
	logic [lngt_pkg::SW-1:0]         s_q;
	logic [lngt_pkg::DW-1:0]         d_q;
	logic [lngt_pkg::RadW-1:0]       sqx_q;
	logic                            ovalid_q;
	lngt_pkg::res_t                  ogap_q [lngt_pkg::NTrack];
	lngt_pkg::res_t                  ospd_q [lngt_pkg::NTrack];

	logic                            accept;
	logic                            out_free;
	logic [lngt_pkg::VelW-1:0]       vxa;
	logic [lngt_pkg::VelW-1:0]       vya;
	logic [lngt_pkg::HsatW-1:0]      h_ext;
	logic [lngt_pkg::HsatW-1:0]      h_sat;
	logic [lngt_pkg::MulW-1:0]       mul_a;
	logic [lngt_pkg::MulW-1:0]       mul_b;
	logic [lngt_pkg::ProdW-1:0]      prod;
	logic [lngt_pkg::RadW-1:0]       radicand;
	logic                            sq_done;
	logic [lngt_pkg::SpeedW-1:0]     speed;
	logic [lngt_pkg::QuotW-1:0]      quot;
	logic [lngt_pkg::PosW-1:0]       pred;
	lngt_pkg::trk_ctl_t              trk_ctl;
	lngt_pkg::res_t                  trk_gap [lngt_pkg::NTrack];
	lngt_pkg::res_t                  trk_spd [lngt_pkg::NTrack];

	assign veh.ready = (state_q == S_IDLE);
	assign accept    = veh.valid && veh.ready;
	assign out_free  = !ovalid_q || res.ready;

	// magnitudes; the most negative value maps to 32768, still 16 bits
	always_comb begin
		vxa   = veh.obj_vx[lngt_pkg::VelW-1] ? lngt_pkg::VelW'(-veh.obj_vx) : veh.obj_vx;
		vya   = veh.obj_vy[lngt_pkg::VelW-1] ? lngt_pkg::VelW'(-veh.obj_vy) : veh.obj_vy;
		h_ext = lngt_pkg::HsatW'(veh.horizon_steps);
		h_sat = (h_ext > lngt_pkg::HsatW'(lngt_pkg::MAX_HORIZON)) ?
			lngt_pkg::HsatW'(lngt_pkg::MAX_HORIZON) : h_ext;
	end

	// multiplier operand select per sequencer step
	always_comb begin
		case (state_q)
			S_SQX: begin
				mul_a = lngt_pkg::MulW'(vxa_q);
				mul_b = lngt_pkg::MulW'(vxa_q);
			end
			S_SQY: begin
				mul_a = lngt_pkg::MulW'(vya_q);
				mul_b = lngt_pkg::MulW'(vya_q);
			end
			S_MULH: begin
				mul_a = lngt_pkg::MulW'(speed);
				mul_b = lngt_pkg::MulW'(h_q);
			end
			S_MULR: begin
				mul_a = lngt_pkg::MulW'(prod[lngt_pkg::DivPreShift +: lngt_pkg::MulW-1]);
				mul_b = lngt_pkg::RecipMul;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	lngt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign radicand = sqx_q + prod[lngt_pkg::RadW-1:0];

	lngt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SUM),
		.radicand (radicand),
		.done     (sq_done),
		.root     (speed)
	);

	always_comb begin
		quot        = prod[lngt_pkg::RecipShift +: lngt_pkg::QuotW];
		pred        = lngt_pkg::PosW'(s_q) + lngt_pkg::PosW'(quot);
		trk_ctl.clr = accept && veh.first;
		trk_ctl.upd = (state_q == S_UPD);
	end

	lngt_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (trk_ctl),
		.lane    (lane_q),
		.d       (d_q),
		.ego     (ego_q),
		.pred    (pred),
		.speed   (speed),
		.gap_out (trk_gap),
		.spd_out (trk_spd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			last_q   <= 1'b0;
			lane_q   <= '0;
			h_q      <= '0;
			ego_q    <= '0;
			vxa_q    <= '0;
			vya_q    <= '0;
			s_q      <= '0;
			d_q      <= '0;
			sqx_q    <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < lngt_pkg::NTrack; i++) begin
				ogap_q[i] <= '0;
				ospd_q[i] <= '0;
			end
		end else begin
			// in the emit step the output register is reloaded instead
			if (ovalid_q && res.ready && state_q != S_EMIT) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= veh.last;
						lane_q  <= veh.ego_lane;
						h_q     <= h_sat;
						ego_q   <= veh.ego_s;
						vxa_q   <= vxa;
						vya_q   <= vya;
						s_q     <= veh.obj_s;
						d_q     <= veh.obj_d;
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					sqx_q   <= prod[lngt_pkg::RadW-1:0];
					state_q <= S_SUM;
				end
				S_SUM: state_q <= S_ROOT;
				S_ROOT: begin
					if (sq_done) begin
						state_q <= S_MULH;
					end
				end
				S_MULH: state_q <= S_MULR;
				S_MULR: state_q <= S_UPD;
				S_UPD: state_q <= last_q ? S_EMIT : S_IDLE;
				S_EMIT: begin
					// wait for the output register to free up
					if (out_free) begin
						for (int i = 0; i < lngt_pkg::NTrack; i++) begin
							ogap_q[i] <= trk_gap[i];
							ospd_q[i] <= trk_spd[i];
						end
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid              = ovalid_q;
	assign res.ahead_gap          = ogap_q[lngt_pkg::TrkAhead];
	assign res.ahead_speed        = ospd_q[lngt_pkg::TrkAhead];
	assign res.left_ahead_gap     = ogap_q[lngt_pkg::TrkLeftAhead];
	assign res.left_ahead_speed   = ospd_q[lngt_pkg::TrkLeftAhead];
	assign res.left_behind_gap    = ogap_q[lngt_pkg::TrkLeftBehind];
	assign res.left_behind_speed  = ospd_q[lngt_pkg::TrkLeftBehind];
	assign res.right_ahead_gap    = ogap_q[lngt_pkg::TrkRightAhead];
	assign res.right_ahead_speed  = ospd_q[lngt_pkg::TrkRightAhead];
	assign res.right_behind_gap   = ogap_q[lngt_pkg::TrkRightBehind];
	assign res.right_behind_speed = ospd_q[lngt_pkg::TrkRightBehind];

endmodule
`default_nettype wire

### hdl/lngt_mul.sv
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module lngt_mul (
	input  wire logic                        clk,
	input  wire logic [lngt_pkg::MulW-1:0]   a,
	input  wire logic [lngt_pkg::MulW-1:0]   b,
	output logic      [lngt_pkg::ProdW-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= lngt_pkg::ProdW'(a) * lngt_pkg::ProdW'(b);
	end

endmodule
`default_nettype wire

### hdl/lngt_sqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module lngt_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lngt_pkg::RadW-1:0]    radicand,
	output logic                              done,
	output logic      [lngt_pkg::SpeedW-1:0]  root
);

	localparam int RemW = lngt_pkg::SpeedW + 1;
	localparam int CntW = $clog2(lngt_pkg::SpeedW);

	logic [lngt_pkg::RadW-1:0]   rad_q;
	logic [RemW-1:0]             rem_q;
	logic [lngt_pkg::SpeedW-1:0] root_q;
	logic [CntW-1:0]             cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [RemW+1:0]             rem_sh;
	logic [RemW:0]               trial;
	logic                        ge;
	logic [RemW+1:0]             rem_diff;

	// bring down two radicand bits, try subtracting 4*root+1
	always_comb begin
		rem_sh   = {rem_q, rad_q[lngt_pkg::RadW-1 -: 2]};
		trial    = {root_q, 2'b01};
		ge       = rem_sh >= {1'b0, trial};
		rem_diff = rem_sh - {1'b0, trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[lngt_pkg::RadW-3:0], 2'b00};
			rem_q  <= ge ? rem_diff[RemW-1:0] : rem_sh[RemW-1:0];
			root_q <= {root_q[lngt_pkg::SpeedW-2:0], ge};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CntW'(lngt_pkg::SpeedW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

### hdl/lngt_track.sv
// five nearest-vehicle trackers: lane tests, gap compare and update
`timescale 1ns / 1ps
`default_nettype none
module lngt_track (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lngt_pkg::trk_ctl_t            ctl,
	input  wire logic [lngt_pkg::LaneW-1:0]    lane,
	input  wire logic [lngt_pkg::DW-1:0]       d,
	input  wire logic [lngt_pkg::PosW-1:0]     ego,
	input  wire logic [lngt_pkg::PosW-1:0]     pred,
	input  wire logic [lngt_pkg::SpeedW-1:0]   speed,
	output lngt_pkg::res_t                     gap_out [lngt_pkg::NTrack],
	output lngt_pkg::res_t                     spd_out [lngt_pkg::NTrack]
);

	logic [lngt_pkg::GapW-1:0]   best_gap_q [lngt_pkg::NTrack];
	logic [lngt_pkg::SpeedW-1:0] best_spd_q [lngt_pkg::NTrack];
	logic [lngt_pkg::NTrack-1:0] found_q;

	logic [lngt_pkg::BandW-1:0]  band;
	logic [lngt_pkg::BandW-1:0]  lane_b;
	logic                        d_nz;
	logic                        in_ego;
	logic                        in_left;
	logic                        in_right;
	logic                        is_ahead;
	logic                        is_behind;
	logic [lngt_pkg::PosW-1:0]   gap_a;
	logic [lngt_pkg::PosW-1:0]   gap_b;
	logic [lngt_pkg::NTrack-1:0] en;
	logic [lngt_pkg::NTrack-1:0] take;
	logic [lngt_pkg::PosW-1:0]   gap [lngt_pkg::NTrack];

	// band k holds 256k < d < 256k+256, both ends open
	always_comb begin
		band      = d[lngt_pkg::DW-1:lngt_pkg::LaneShift];
		lane_b    = lngt_pkg::BandW'(lane);
		d_nz      = d[lngt_pkg::LaneShift-1:0] != '0;
		in_ego    = d_nz && (band == lane_b);
		in_left   = d_nz && (lane != '0) && (band == lane_b - 1'b1);
		in_right  = d_nz && (lane < lngt_pkg::RightmostLane) && (band == lane_b + 1'b1);
		is_ahead  = pred > ego;
		is_behind = pred < ego;
		gap_a     = pred - ego;
		gap_b     = ego - pred;

		en[lngt_pkg::TrkAhead]        = in_ego && is_ahead;
		en[lngt_pkg::TrkLeftAhead]    = in_left && is_ahead;
		en[lngt_pkg::TrkLeftBehind]   = in_left && is_behind;
		en[lngt_pkg::TrkRightAhead]   = in_right && is_ahead;
		en[lngt_pkg::TrkRightBehind]  = in_right && is_behind;
		gap[lngt_pkg::TrkAhead]       = gap_a;
		gap[lngt_pkg::TrkLeftAhead]   = gap_a;
		gap[lngt_pkg::TrkLeftBehind]  = gap_b;
		gap[lngt_pkg::TrkRightAhead]  = gap_a;
		gap[lngt_pkg::TrkRightBehind] = gap_b;

		for (int i = 0; i < lngt_pkg::NTrack; i++) begin
			// strict compare keeps the earlier vehicle on a tie
			take[i] = en[i] && (gap[i] < lngt_pkg::PosW'(best_gap_q[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lngt_pkg::NTrack; i++) begin
				best_gap_q[i] <= lngt_pkg::GAP_LIMIT;
				best_spd_q[i] <= '0;
			end
			found_q <= '0;
		end else if (ctl.clr) begin
			for (int i = 0; i < lngt_pkg::NTrack; i++) begin
				best_gap_q[i] <= lngt_pkg::GAP_LIMIT;
				best_spd_q[i] <= '0;
			end
			found_q <= '0;
		end else if (ctl.upd) begin
			for (int i = 0; i < lngt_pkg::NTrack; i++) begin
				if (take[i]) begin
					best_gap_q[i] <= gap[i][lngt_pkg::GapW-1:0];
					best_spd_q[i] <= speed;
					found_q[i]    <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < lngt_pkg::NTrack; i++) begin
			gap_out[i] = found_q[i] ? lngt_pkg::res_t'({1'b0, best_gap_q[i]}) : '1;
			spd_out[i] = found_q[i] ? lngt_pkg::res_t'({1'b0, best_spd_q[i]}) : '1;
		end
	end

endmodule
`default_nettype wire
